### rtl/core/assert_macros.svh
// concurrent assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_SYNC(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next, outside reset
`define ASSERT_SYNC_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/prcf_pkg.sv
// package: types, constants and arithmetic helpers of the temporal rc filter
`default_nettype none

package prcf_pkg;

  localparam int ROWS_DEF     = 240;
  localparam int COLS_DEF     = 320;
  localparam int CHANNELS_DEF = 3;
  localparam int MAX_LANES    = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REDUCE_SHIFT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RC_PRODUCT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_COEFF  = 3'd4;

  localparam logic MODE_HIGH_PASS = 1'b0;
  localparam logic MODE_LOW_PASS  = 1'b1;

  localparam logic [15:0] RC_PRODUCT_RST  = 16'd256;
  localparam logic [15:0] STEP_SIZE_RST   = 16'd6554;
  localparam logic [23:0] ACCEL_COEFF_RST = 24'd2560;

  localparam logic signed [63:0] SAT_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN   = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [31:0] QUANT_TOP = 32'sh00FF_0000;
  localparam logic [7:0]          QUANT_MAX = 8'd255;

  typedef struct packed {
    logic [7:0] pixel_row;
    logic [8:0] pixel_col;
    logic [7:0] cur_ch0;
    logic [7:0] cur_ch1;
    logic [7:0] cur_ch2;
    logic [7:0] prev_ch0;
    logic [7:0] prev_ch1;
    logic [7:0] prev_ch2;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_row;
    logic [8:0] out_col;
    logic [7:0] quant_ch0;
    logic [7:0] quant_ch1;
    logic [7:0] quant_ch2;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = SAT_MAX[31:0];
    end else if (x < SAT_MIN) begin
      r = SAT_MIN[31:0];
    end else begin
      r = $signed(x[31:0]);
    end
    return r;
  endfunction

  function automatic logic [7:0] quant(input logic signed [31:0] v);
    logic [7:0] q;
    if (v < 0) begin
      q = '0;
    end else if (v > QUANT_TOP) begin
      q = QUANT_MAX;
    end else begin
      q = v[23:16];
    end
    return q;
  endfunction

endpackage

`default_nettype wire

### rtl/core/prcf_stream_if.sv
// valid/ready stream interface carrying one payload per transaction
`default_nettype none

interface prcf_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/pixel_temporal_rc_filter_core.sv
// Per-pixel temporal rc filter: one pixel transaction per clock unless stalled by the result
// stream, a hazard or the clearing pass; one result per pixel on the subsampling grid inside
// the frame, registered at the output after the pipeline. Filter value and slope of every
// pixel live in two single-port-read, single-port-write memories of ROWS*COLS words; a used
// pixel is read, run through a five-stage multiply/saturate pipeline and written back. A used
// pixel whose address is still in that pipeline waits until the earlier one has been written
// back, so a pixel repeated in flight stalls the stream. After reset a clearing pass zeroes
// both memories, one word per cycle; no pixel is accepted until it ends. Registers are written
// with cfg_we, cfg_index and cfg_data, by the user only while the filter is idle; not enforced.
`default_nettype none

module pixel_temporal_rc_filter_core #(
  parameter int ROWS     = prcf_pkg::ROWS_DEF,
  parameter int COLS     = prcf_pkg::COLS_DEF,
  parameter int CHANNELS = prcf_pkg::CHANNELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [prcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prcf_pkg::CFG_DATA_W-1:0] cfg_data,
  prcf_stream_if.sink                          pixel,
  prcf_stream_if.source                        result
);

  import prcf_pkg::*;

  `include "assert_macros.svh"

  localparam int NCH   = (CHANNELS < MAX_LANES) ? CHANNELS : MAX_LANES;
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = NCH * 32;

  // configuration
  logic        filter_mode;
  logic [1:0]  reduce_shift;
  logic [15:0] rc_product;
  logic [15:0] step_size;
  logic [23:0] accel_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_HIGH_PASS;
      reduce_shift <= '0;
      rc_product   <= RC_PRODUCT_RST;
      step_size    <= STEP_SIZE_RST;
      accel_coeff  <= ACCEL_COEFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_MODE:  filter_mode  <= cfg_data[0];
        REG_REDUCE_SHIFT: reduce_shift <= cfg_data[1:0];
        REG_RC_PRODUCT:   rc_product   <= cfg_data[15:0];
        REG_STEP_SIZE:    step_size    <= cfg_data[15:0];
        REG_ACCEL_COEFF:  accel_coeff  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic          clearing;
  logic [AW-1:0] clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + AW'(1);
      if (clear_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // pipeline control
  logic [5:1] st_valid;
  logic [5:1] ld;
  logic       ld_out;
  logic       wr_en;

  logic [AW-1:0]     st_addr [1:5];
  logic [7:0]        st_row  [1:5];
  logic [8:0]        st_col  [1:5];
  logic signed [8:0] st_din  [1:3][NCH];

  always_comb begin
    ld_out = !result.valid || result.ready;
    ld[5]  = !st_valid[5] || ld_out;
    for (int k = 4; k >= 1; k--) begin
      ld[k] = !st_valid[k] || ld[k+1];
    end
  end

  assign wr_en = st_valid[5] && ld_out;

  // input decode
  logic [2:0]    gmask;
  logic          on_grid;
  logic          in_frame;
  logic          use_in;
  logic [AW-1:0] in_addr;
  logic          hazard;
  logic          accept;
  logic [7:0]    in_cur  [MAX_LANES];
  logic [7:0]    in_prev [MAX_LANES];

  always_comb begin
    unique case (reduce_shift)
      2'd0: gmask = 3'b000;
      2'd1: gmask = 3'b001;
      2'd2: gmask = 3'b011;
      2'd3: gmask = 3'b111;
      default: gmask = 3'b000;
    endcase
    on_grid  = ((pixel.payload.pixel_row[2:0] & gmask) == 3'b000)
            && ((pixel.payload.pixel_col[2:0] & gmask) == 3'b000);
    in_frame = (32'(pixel.payload.pixel_row) < 32'(ROWS))
            && (32'(pixel.payload.pixel_col) < 32'(COLS));
    use_in   = on_grid && in_frame;
    in_addr  = AW'(AW'(pixel.payload.pixel_row) * AW'(COLS)) + AW'(pixel.payload.pixel_col);
    hazard   = 1'b0;
    for (int k = 1; k <= 5; k++) begin
      if (st_valid[k] && st_addr[k] == in_addr) begin
        hazard = 1'b1;
      end
    end
    in_cur[0]  = pixel.payload.cur_ch0;
    in_cur[1]  = pixel.payload.cur_ch1;
    in_cur[2]  = pixel.payload.cur_ch2;
    in_prev[0] = pixel.payload.prev_ch0;
    in_prev[1] = pixel.payload.prev_ch1;
    in_prev[2] = pixel.payload.prev_ch2;
  end

  assign pixel.ready = ld[1] && !clearing && !(use_in && hazard);
  assign accept      = pixel.valid && pixel.ready;

  // memories
  logic [WW-1:0] val_mem   [DEPTH];
  logic [WW-1:0] slope_mem [DEPTH];
  logic [WW-1:0] val_rd;
  logic [WW-1:0] slope_rd;
  logic [WW-1:0] val_wr;
  logic [WW-1:0] slope_wr;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      val_rd   <= val_mem[st_addr[1]];
      slope_rd <= slope_mem[st_addr[1]];
    end
    if (clearing) begin
      val_mem[clear_addr]   <= '0;
      slope_mem[clear_addr] <= '0;
    end else if (wr_en) begin
      val_mem[st_addr[5]] <= val_wr;
      if (filter_mode == MODE_LOW_PASS) begin
        slope_mem[st_addr[5]] <= slope_wr;
      end
    end
  end

  // datapath lanes
  logic signed [31:0] v2   [NCH];
  logic signed [31:0] dv2  [NCH];
  logic signed [48:0] p2a  [NCH];
  logic signed [57:0] p2b  [NCH];
  logic signed [48:0] p3a  [NCH];
  logic signed [57:0] p3b  [NCH];
  logic signed [31:0] v3   [NCH];
  logic signed [31:0] dv3  [NCH];
  logic signed [31:0] x3   [NCH];
  logic signed [31:0] ndv3 [NCH];
  logic signed [31:0] x4   [NCH];
  logic signed [31:0] ndv4 [NCH];
  logic signed [31:0] v4   [NCH];
  logic signed [48:0] p4   [NCH];
  logic signed [48:0] p5   [NCH];
  logic signed [31:0] x5   [NCH];
  logic signed [31:0] ndv5 [NCH];
  logic signed [31:0] v5   [NCH];
  logic signed [31:0] nv5  [NCH];
  logic [7:0]         q5   [MAX_LANES];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      logic signed [31:0] mul_a;
      logic signed [16:0] mul_b;
      logic signed [32:0] diff;
      logic signed [24:0] din16;
      v2[c]  = $signed(val_rd[c*32 +: 32]);
      dv2[c] = $signed(slope_rd[c*32 +: 32]);
      mul_a  = (filter_mode == MODE_HIGH_PASS) ? v2[c] : dv2[c];
      mul_b  = $signed({1'b0, (filter_mode == MODE_HIGH_PASS) ? rc_product : step_size});
      p2a[c] = 49'(mul_a * mul_b);
      din16  = $signed({st_din[2][c], 16'h0000});
      diff   = 33'(din16) - 33'(dv2[c]);
      p2b[c] = 58'(diff * $signed({1'b0, accel_coeff}));
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      logic signed [24:0] din16;
      din16 = $signed({st_din[3][c], 16'h0000});
      if (filter_mode == MODE_HIGH_PASS) begin
        x3[c] = sat32(64'(din16) - 64'(p3a[c] >>> 8));
      end else begin
        x3[c] = sat32(64'(v3[c]) + 64'(p3a[c] >>> 16));
      end
      ndv3[c] = sat32(64'(dv3[c]) + 64'(p3b[c] >>> 8));
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      p4[c] = 49'(x4[c] * $signed({1'b0, step_size}));
    end
  end

  always_comb begin
    val_wr   = '0;
    slope_wr = '0;
    for (int c = 0; c < MAX_LANES; c++) begin
      q5[c] = '0;
    end
    for (int c = 0; c < NCH; c++) begin
      if (filter_mode == MODE_HIGH_PASS) begin
        nv5[c] = sat32(64'(v5[c]) + 64'(p5[c] >>> 16));
        q5[c]  = quant(nv5[c]);
      end else begin
        nv5[c] = x5[c];
        q5[c]  = quant(v5[c]);
      end
      val_wr[c*32 +: 32]   = nv5[c];
      slope_wr[c*32 +: 32] = ndv5[c];
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else begin
      if (ld[1]) begin
        st_valid[1] <= accept && use_in;
      end
      for (int k = 2; k <= 5; k++) begin
        if (ld[k]) begin
          st_valid[k] <= st_valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      st_addr[1] <= in_addr;
      st_row[1]  <= pixel.payload.pixel_row >> reduce_shift;
      st_col[1]  <= pixel.payload.pixel_col >> reduce_shift;
      for (int c = 0; c < NCH; c++) begin
        st_din[1][c] <= $signed({1'b0, in_cur[c]}) - $signed({1'b0, in_prev[c]});
      end
    end
    for (int k = 2; k <= 5; k++) begin
      if (ld[k]) begin
        st_addr[k] <= st_addr[k-1];
        st_row[k]  <= st_row[k-1];
        st_col[k]  <= st_col[k-1];
      end
    end
    for (int k = 2; k <= 3; k++) begin
      if (ld[k]) begin
        st_din[k] <= st_din[k-1];
      end
    end
    if (ld[3]) begin
      p3a <= p2a;
      p3b <= p2b;
      v3  <= v2;
      dv3 <= dv2;
    end
    if (ld[4]) begin
      x4   <= x3;
      ndv4 <= ndv3;
      v4   <= v3;
    end
    if (ld[5]) begin
      p5   <= p4;
      x5   <= x4;
      ndv5 <= ndv4;
      v5   <= v4;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ld_out) begin
      result.valid <= st_valid[5];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      result.payload.out_row   <= st_row[5];
      result.payload.out_col   <= st_col[5];
      result.payload.quant_ch0 <= q5[0];
      result.payload.quant_ch1 <= q5[1];
      result.payload.quant_ch2 <= q5[2];
    end
  end

  // assertions
  `ASSERT_SYNC(a_no_work_while_clearing, !clearing || st_valid == '0, "pixel in flight during clearing pass")
  `ASSERT_SYNC(a_addr_unique_1_5, !(st_valid[1] && st_valid[5]) || st_addr[1] != st_addr[5], "same pixel twice in pipeline")
  `ASSERT_SYNC(a_addr_unique_2_4, !(st_valid[2] && st_valid[4]) || st_addr[2] != st_addr[4], "same pixel twice in pipeline")
  `ASSERT_SYNC_NEXT(a_drain_empty, result.valid && result.ready && !st_valid[5], !result.valid, "result appeared from empty stage")

endmodule

`default_nettype wire
